// ===== rtl/core/rtc_apt_pkg.sv =====
`default_nettype none

package rtc_apt_pkg;

  // Item kinds carried in the func field of a request.
  typedef enum logic [2:0] {
    FUNC_READ      = 3'd0,
    FUNC_WRITE     = 3'd1,
    FUNC_RTC_TICK  = 3'd2,
    FUNC_TCLK_TICK = 3'd3,
    FUNC_RTC_RST   = 3'd4,
    FUNC_OTHER_RST = 3'd5
  } func_e;

  // Register bank select.
  localparam logic BANK_RTC1 = 1'b0;
  localparam logic BANK_RTC2 = 1'b1;

  // Bank 0 halfword offsets.
  localparam logic [4:0] OFF_ETIME_L  = 5'h00;
  localparam logic [4:0] OFF_ETIME_M  = 5'h02;
  localparam logic [4:0] OFF_ETIME_H  = 5'h04;
  localparam logic [4:0] OFF_ECMP_L   = 5'h08;
  localparam logic [4:0] OFF_ECMP_M   = 5'h0A;
  localparam logic [4:0] OFF_ECMP_H   = 5'h0C;
  localparam logic [4:0] OFF_L1_REL_L = 5'h10;
  localparam logic [4:0] OFF_L1_REL_H = 5'h12;
  localparam logic [4:0] OFF_L1_CNT_L = 5'h14;
  localparam logic [4:0] OFF_L1_CNT_H = 5'h16;
  localparam logic [4:0] OFF_L2_REL_L = 5'h18;
  localparam logic [4:0] OFF_L2_REL_H = 5'h1A;
  localparam logic [4:0] OFF_L2_CNT_L = 5'h1C;
  localparam logic [4:0] OFF_L2_CNT_H = 5'h1E;

  // Bank 1 halfword offsets.
  localparam logic [4:0] OFF_TC_REL_L = 5'h00;
  localparam logic [4:0] OFF_TC_REL_H = 5'h02;
  localparam logic [4:0] OFF_TC_CNT_L = 5'h04;
  localparam logic [4:0] OFF_TC_CNT_H = 5'h06;
  localparam logic [4:0] OFF_INT_STAT = 5'h1E;

  // Status bit positions.
  localparam int unsigned STAT_ELAPSED = 0;
  localparam int unsigned STAT_LONG1   = 1;
  localparam int unsigned STAT_LONG2   = 2;
  localparam int unsigned STAT_TCLOCK  = 3;

  // Outcome of one tick of a reloading down counter.
  typedef struct packed {
    logic        wrap;
    logic [24:0] cnt;
  } tick_t;

  // A zero reload holds the counter at zero; otherwise it counts down to one
  // and then reloads, flagging the wrap.
  function automatic tick_t tick_down(input logic [24:0] rel, input logic [24:0] cnt);
    tick_t res;
    res.wrap = 1'b0;
    res.cnt  = cnt - 25'd1;
    if (rel == '0) begin
      res.cnt = '0;
    end else if (cnt <= 25'd1) begin
      res.cnt  = rel;
      res.wrap = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtc_apt_if.sv =====
`default_nettype none

// Request channel: one bus access, tick or reset per request.
interface rtc_apt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic        bank;
  logic [4:0]  offset;
  logic [15:0] write_data;

  modport source (output valid, output func, output bank, output offset,
                  output write_data, input ready);
  modport sink   (input valid, input func, input bank, input offset,
                  input write_data, output ready);
endinterface

// Response channel: read data, interrupt levels and access error.
interface rtc_apt_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq_elapsed;
  logic        irq_long1;
  logic        irq_long2;
  logic        irq_tclock;
  logic        bad_access;

  modport source (output valid, output read_data, output irq_elapsed, output irq_long1,
                  output irq_long2, output irq_tclock, output bad_access, input ready);
  modport sink   (input valid, input read_data, input irq_elapsed, input irq_long1,
                  input irq_long2, input irq_tclock, input bad_access, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rtc_alarm_and_periodic_timers_top.sv =====
`default_nettype none

// Channel   Direction  Contents
// req_i     in         func, bank, offset, write_data
// rsp_o     out        read_data, irq_elapsed/long1/long2/tclock, bad_access
//
// Each request is registered, then processed against the timer state while
// its response is loaded into the output register; one request per cycle is
// sustained while the response side takes each response.
// Reset clears all timer state, the status bits and both valid flags.
// A stalled response holds the request stage; the input keeps accepting as
// long as the request stage is empty or moving on.
module rtc_alarm_and_periodic_timers_top
  import rtc_apt_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  rtc_apt_req_if.sink         req_i,
  rtc_apt_rsp_if.source       rsp_o
);

  // Request stage.
  logic        s1_valid_q;
  logic [2:0]  s1_func_q;
  logic        s1_bank_q;
  logic [4:0]  s1_off_q;
  logic [15:0] s1_wdata_q;

  // Response register.
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic [3:0]  out_irq_q;
  logic        out_bad_q;

  // Timer state.
  logic [47:0] etime_q,   etime_d;
  logic [31:0] staged_q,  staged_d;
  logic [47:0] ecmp_q,    ecmp_d;
  logic        armed_q,   armed_d;
  logic [23:0] l1_rel_q,  l1_rel_d;
  logic [23:0] l1_cnt_q,  l1_cnt_d;
  logic [23:0] l2_rel_q,  l2_rel_d;
  logic [23:0] l2_cnt_q,  l2_cnt_d;
  logic [24:0] tc_rel_q,  tc_rel_d;
  logic [24:0] tc_cnt_q,  tc_cnt_d;
  logic [3:0]  status_q,  status_d;

  logic        s1_adv;
  logic        s1_fire;
  logic [15:0] rdata;
  logic        bad;
  logic [23:0] l1_cnt_vis;
  logic [23:0] l2_cnt_vis;
  logic [24:0] tc_cnt_vis;
  tick_t       l1_tick;
  tick_t       l2_tick;
  tick_t       tc_tick;
  func_e       func;

  // Handshake: both stages move together when the response slot frees up.
  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign req_i.ready = !s1_valid_q || s1_adv;

  assign func = func_e'(s1_func_q);

  // A stopped counter always reads as zero.
  assign l1_cnt_vis = (l1_rel_q != '0) ? l1_cnt_q : '0;
  assign l2_cnt_vis = (l2_rel_q != '0) ? l2_cnt_q : '0;
  assign tc_cnt_vis = (tc_rel_q != '0) ? tc_cnt_q : '0;

  assign l1_tick = tick_down({1'b0, l1_rel_q}, {1'b0, l1_cnt_q});
  assign l2_tick = tick_down({1'b0, l2_rel_q}, {1'b0, l2_cnt_q});
  assign tc_tick = tick_down(tc_rel_q, tc_cnt_q);

  // Register reads.
  always_comb begin
    rdata = '0;
    bad   = 1'b0;
    if (s1_bank_q == BANK_RTC1) begin
      case (s1_off_q)
        OFF_ETIME_L:  rdata = etime_q[15:0];
        OFF_ETIME_M:  rdata = etime_q[31:16];
        OFF_ETIME_H:  rdata = etime_q[47:32];
        OFF_ECMP_L:   rdata = ecmp_q[15:0];
        OFF_ECMP_M:   rdata = ecmp_q[31:16];
        OFF_ECMP_H:   rdata = ecmp_q[47:32];
        OFF_L1_REL_L: rdata = l1_rel_q[15:0];
        OFF_L1_REL_H: rdata = {8'h00, l1_rel_q[23:16]};
        OFF_L1_CNT_L: rdata = l1_cnt_vis[15:0];
        OFF_L1_CNT_H: rdata = {8'h00, l1_cnt_vis[23:16]};
        OFF_L2_REL_L: rdata = l2_rel_q[15:0];
        OFF_L2_REL_H: rdata = {8'h00, l2_rel_q[23:16]};
        OFF_L2_CNT_L: rdata = l2_cnt_vis[15:0];
        OFF_L2_CNT_H: rdata = {8'h00, l2_cnt_vis[23:16]};
        default:      bad   = 1'b1;
      endcase
    end else begin
      case (s1_off_q)
        OFF_TC_REL_L: rdata = tc_rel_q[15:0];
        OFF_TC_REL_H: rdata = {7'h00, tc_rel_q[24:16]};
        OFF_TC_CNT_L: rdata = tc_cnt_vis[15:0];
        OFF_TC_CNT_H: rdata = {7'h00, tc_cnt_vis[24:16]};
        OFF_INT_STAT: rdata = {12'h000, status_q};
        default:      bad   = 1'b1;
      endcase
    end
  end

  // Next state for the request in the stage, alarm check last.
  always_comb begin
    etime_d  = etime_q;
    staged_d = staged_q;
    ecmp_d   = ecmp_q;
    armed_d  = armed_q;
    l1_rel_d = l1_rel_q;
    l1_cnt_d = l1_cnt_q;
    l2_rel_d = l2_rel_q;
    l2_cnt_d = l2_cnt_q;
    tc_rel_d = tc_rel_q;
    tc_cnt_d = tc_cnt_q;
    status_d = status_q;
    case (func)
      FUNC_WRITE: begin
        if (s1_bank_q == BANK_RTC1) begin
          case (s1_off_q)
            OFF_ETIME_L:  staged_d[15:0]  = s1_wdata_q;
            OFF_ETIME_M:  staged_d[31:16] = s1_wdata_q;
            OFF_ETIME_H:  etime_d = {s1_wdata_q, staged_q};
            OFF_ECMP_L:   ecmp_d[15:0]  = s1_wdata_q;
            OFF_ECMP_M:   ecmp_d[31:16] = s1_wdata_q;
            OFF_ECMP_H: begin
              ecmp_d[47:32] = s1_wdata_q;
              armed_d       = 1'b1;
            end
            OFF_L1_REL_L: begin
              l1_rel_d = {l1_rel_q[23:16], s1_wdata_q};
              l1_cnt_d = {l1_rel_q[23:16], s1_wdata_q};
            end
            OFF_L1_REL_H: begin
              l1_rel_d = {s1_wdata_q[7:0], l1_rel_q[15:0]};
              l1_cnt_d = {s1_wdata_q[7:0], l1_rel_q[15:0]};
            end
            OFF_L2_REL_L: begin
              l2_rel_d = {l2_rel_q[23:16], s1_wdata_q};
              l2_cnt_d = {l2_rel_q[23:16], s1_wdata_q};
            end
            OFF_L2_REL_H: begin
              l2_rel_d = {s1_wdata_q[7:0], l2_rel_q[15:0]};
              l2_cnt_d = {s1_wdata_q[7:0], l2_rel_q[15:0]};
            end
            default: ;
          endcase
        end else begin
          case (s1_off_q)
            OFF_TC_REL_L: begin
              tc_rel_d = {tc_rel_q[24:16], s1_wdata_q};
              tc_cnt_d = {tc_rel_q[24:16], s1_wdata_q};
            end
            OFF_TC_REL_H: begin
              tc_rel_d = {s1_wdata_q[8:0], tc_rel_q[15:0]};
              tc_cnt_d = {s1_wdata_q[8:0], tc_rel_q[15:0]};
            end
            OFF_INT_STAT: status_d = status_q & ~s1_wdata_q[3:0];
            default: ;
          endcase
        end
      end
      FUNC_RTC_TICK: begin
        etime_d  = etime_q + 48'd1;
        l1_cnt_d = l1_tick.cnt[23:0];
        l2_cnt_d = l2_tick.cnt[23:0];
        status_d[STAT_LONG1] = status_q[STAT_LONG1] | l1_tick.wrap;
        status_d[STAT_LONG2] = status_q[STAT_LONG2] | l2_tick.wrap;
      end
      FUNC_TCLK_TICK: begin
        tc_cnt_d = tc_tick.cnt;
        status_d[STAT_TCLOCK] = status_q[STAT_TCLOCK] | tc_tick.wrap;
      end
      FUNC_RTC_RST: begin
        etime_d  = '0;
        staged_d = '0;
        ecmp_d   = '0;
        armed_d  = 1'b0;
        l1_rel_d = '0;
        l1_cnt_d = '0;
        l2_rel_d = '0;
        l2_cnt_d = '0;
        tc_rel_d = '0;
        tc_cnt_d = '0;
        status_d = '0;
      end
      FUNC_OTHER_RST: begin
        tc_rel_d = '0;
        tc_cnt_d = '0;
        status_d[STAT_TCLOCK] = 1'b0;
      end
      default: ;
    endcase
    // One-shot alarm against the updated counter and compare value.
    if (armed_d && (etime_d >= ecmp_d)) begin
      status_d[STAT_ELAPSED] = 1'b1;
      armed_d                = 1'b0;
    end
  end

  // Request stage and response register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Request payload.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_func_q  <= req_i.func;
      s1_bank_q  <= req_i.bank;
      s1_off_q   <= req_i.offset;
      s1_wdata_q <= req_i.write_data;
    end
  end

  // Response payload; an access error or a non-read gives zero data.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= (func == FUNC_READ && !bad) ? rdata : '0;
      out_irq_q  <= status_d;
      out_bad_q  <= (func == FUNC_READ || func == FUNC_WRITE) && bad;
    end
  end

  // Timer state, committed as each request passes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etime_q  <= '0;
      staged_q <= '0;
      ecmp_q   <= '0;
      armed_q  <= 1'b0;
      l1_rel_q <= '0;
      l1_cnt_q <= '0;
      l2_rel_q <= '0;
      l2_cnt_q <= '0;
      tc_rel_q <= '0;
      tc_cnt_q <= '0;
      status_q <= '0;
    end else if (s1_fire) begin
      etime_q  <= etime_d;
      staged_q <= staged_d;
      ecmp_q   <= ecmp_d;
      armed_q  <= armed_d;
      l1_rel_q <= l1_rel_d;
      l1_cnt_q <= l1_cnt_d;
      l2_rel_q <= l2_rel_d;
      l2_cnt_q <= l2_cnt_d;
      tc_rel_q <= tc_rel_d;
      tc_cnt_q <= tc_cnt_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_data   = out_data_q;
  assign rsp_o.irq_elapsed = out_irq_q[STAT_ELAPSED];
  assign rsp_o.irq_long1   = out_irq_q[STAT_LONG1];
  assign rsp_o.irq_long2   = out_irq_q[STAT_LONG2];
  assign rsp_o.irq_tclock  = out_irq_q[STAT_TCLOCK];
  assign rsp_o.bad_access  = out_bad_q;

endmodule

`default_nettype wire

// ===== sim/rtc_alarm_and_periodic_timers_top_test.sv =====
module rtc_alarm_and_periodic_timers_top_test;
  import rtc_apt_pkg::*;

  // Offsets that no register decodes, used to provoke bad accesses.
  localparam logic [4:0] OFF_BANK0_HOLE = 5'h06;
  localparam logic [4:0] OFF_ODD        = 5'h13;
  localparam logic [4:0] OFF_BANK1_HOLE = 5'h08;
  localparam logic [4:0] OFF_BANK1_FAR  = 5'h10;

  // One response as the checker sees it; irq is {tclock, long2, long1, elapsed}.
  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  irq;
    logic        bad_access;
  } timer_rsp_t;

  logic clk_i;
  logic rst_ni;

  rtc_apt_req_if req_ch ();
  rtc_apt_rsp_if rsp_ch ();

  rtc_alarm_and_periodic_timers_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Predicted timer state, updated as each request is presented.
  logic [47:0] elapsed_q;
  logic [31:0] elapsed_stage_q;
  logic [47:0] alarm_cmp_q;
  logic        alarm_armed_q;
  logic [23:0] long1_rel_q;
  logic [23:0] long1_cnt_q;
  logic [23:0] long2_rel_q;
  logic [23:0] long2_cnt_q;
  logic [24:0] tclk_rel_q;
  logic [24:0] tclk_cnt_q;
  logic [3:0]  status_q;

  timer_rsp_t  expected_rsp_q[$];
  int unsigned requests_sent;
  int unsigned failures;
  bit          steady_traffic;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // One step of a reloading down counter; returns {wrap, next count}.
  function automatic logic [25:0] count_down(input logic [24:0] rel, input logic [24:0] cnt);
    if (rel == '0) begin
      return '0;
    end
    if (cnt <= 25'd1) begin
      return {1'b1, rel};
    end
    return {1'b0, cnt - 25'd1};
  endfunction

  task automatic clear_timer_model();
    elapsed_q       = '0;
    elapsed_stage_q = '0;
    alarm_cmp_q     = '0;
    alarm_armed_q   = 1'b0;
    long1_rel_q     = '0;
    long1_cnt_q     = '0;
    long2_rel_q     = '0;
    long2_cnt_q     = '0;
    tclk_rel_q      = '0;
    tclk_cnt_q      = '0;
    status_q        = '0;
  endtask

  // Applies one request to the predicted state and works out its response.
  task automatic predict_timer_response(input func_e func, input logic bank,
                                        input logic [4:0] off, input logic [15:0] wd,
                                        output timer_rsp_t rsp);
    logic [25:0] step;
    logic        ok;
    logic [15:0] data;
    ok   = 1'b1;
    data = '0;
    case (func)
      FUNC_READ: begin
        if (bank == BANK_RTC1) begin
          case (off)
            OFF_ETIME_L:  data = elapsed_q[15:0];
            OFF_ETIME_M:  data = elapsed_q[31:16];
            OFF_ETIME_H:  data = elapsed_q[47:32];
            OFF_ECMP_L:   data = alarm_cmp_q[15:0];
            OFF_ECMP_M:   data = alarm_cmp_q[31:16];
            OFF_ECMP_H:   data = alarm_cmp_q[47:32];
            OFF_L1_REL_L: data = long1_rel_q[15:0];
            OFF_L1_REL_H: data = {8'h00, long1_rel_q[23:16]};
            OFF_L1_CNT_L: data = (long1_rel_q != '0) ? long1_cnt_q[15:0] : '0;
            OFF_L1_CNT_H: data = (long1_rel_q != '0) ? {8'h00, long1_cnt_q[23:16]} : '0;
            OFF_L2_REL_L: data = long2_rel_q[15:0];
            OFF_L2_REL_H: data = {8'h00, long2_rel_q[23:16]};
            OFF_L2_CNT_L: data = (long2_rel_q != '0) ? long2_cnt_q[15:0] : '0;
            OFF_L2_CNT_H: data = (long2_rel_q != '0) ? {8'h00, long2_cnt_q[23:16]} : '0;
            default:      ok = 1'b0;
          endcase
        end else begin
          case (off)
            OFF_TC_REL_L: data = tclk_rel_q[15:0];
            OFF_TC_REL_H: data = {7'h00, tclk_rel_q[24:16]};
            OFF_TC_CNT_L: data = (tclk_rel_q != '0) ? tclk_cnt_q[15:0] : '0;
            OFF_TC_CNT_H: data = (tclk_rel_q != '0) ? {7'h00, tclk_cnt_q[24:16]} : '0;
            OFF_INT_STAT: data = {12'h000, status_q};
            default:      ok = 1'b0;
          endcase
        end
      end
      FUNC_WRITE: begin
        if (bank == BANK_RTC1) begin
          case (off)
            OFF_ETIME_L: elapsed_stage_q[15:0] = wd;
            OFF_ETIME_M: elapsed_stage_q[31:16] = wd;
            OFF_ETIME_H: elapsed_q = {wd, elapsed_stage_q};
            OFF_ECMP_L:  alarm_cmp_q[15:0] = wd;
            OFF_ECMP_M:  alarm_cmp_q[31:16] = wd;
            OFF_ECMP_H: begin
              alarm_cmp_q[47:32] = wd;
              alarm_armed_q      = 1'b1;
            end
            OFF_L1_REL_L: begin
              long1_rel_q = {long1_rel_q[23:16], wd};
              long1_cnt_q = long1_rel_q;
            end
            OFF_L1_REL_H: begin
              long1_rel_q = {wd[7:0], long1_rel_q[15:0]};
              long1_cnt_q = long1_rel_q;
            end
            OFF_L2_REL_L: begin
              long2_rel_q = {long2_rel_q[23:16], wd};
              long2_cnt_q = long2_rel_q;
            end
            OFF_L2_REL_H: begin
              long2_rel_q = {wd[7:0], long2_rel_q[15:0]};
              long2_cnt_q = long2_rel_q;
            end
            OFF_L1_CNT_L, OFF_L1_CNT_H, OFF_L2_CNT_L, OFF_L2_CNT_H: ;
            default: ok = 1'b0;
          endcase
        end else begin
          case (off)
            OFF_TC_REL_L: begin
              tclk_rel_q = {tclk_rel_q[24:16], wd};
              tclk_cnt_q = tclk_rel_q;
            end
            OFF_TC_REL_H: begin
              tclk_rel_q = {wd[8:0], tclk_rel_q[15:0]};
              tclk_cnt_q = tclk_rel_q;
            end
            OFF_TC_CNT_L, OFF_TC_CNT_H: ;
            OFF_INT_STAT: status_q = status_q & ~wd[3:0];
            default:      ok = 1'b0;
          endcase
        end
      end
      FUNC_RTC_TICK: begin
        elapsed_q   = elapsed_q + 48'd1;
        step        = count_down({1'b0, long1_rel_q}, {1'b0, long1_cnt_q});
        long1_cnt_q = step[23:0];
        if (step[25]) status_q[STAT_LONG1] = 1'b1;
        step        = count_down({1'b0, long2_rel_q}, {1'b0, long2_cnt_q});
        long2_cnt_q = step[23:0];
        if (step[25]) status_q[STAT_LONG2] = 1'b1;
      end
      FUNC_TCLK_TICK: begin
        step       = count_down(tclk_rel_q, tclk_cnt_q);
        tclk_cnt_q = step[24:0];
        if (step[25]) status_q[STAT_TCLOCK] = 1'b1;
      end
      FUNC_RTC_RST: clear_timer_model();
      FUNC_OTHER_RST: begin
        tclk_rel_q            = '0;
        tclk_cnt_q            = '0;
        status_q[STAT_TCLOCK] = 1'b0;
      end
      default: ;
    endcase
    // The alarm fires once, on the first request that leaves elapsed at or past compare.
    if (alarm_armed_q && elapsed_q >= alarm_cmp_q) begin
      status_q[STAT_ELAPSED] = 1'b1;
      alarm_armed_q          = 1'b0;
    end
    rsp.read_data  = data;
    rsp.irq        = status_q;
    rsp.bad_access = ~ok;
  endtask

  // Presents one request after a random gap (none in steady traffic) and returns at the edge that accepts it.
  // The expectation is queued before the request can possibly be answered.
  task automatic send_req(input func_e func, input logic bank, input logic [4:0] off,
                          input logic [15:0] wd);
    int unsigned gap;
    timer_rsp_t  rsp;
    gap = steady_traffic ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.bank       <= bank;
    req_ch.offset     <= off;
    req_ch.write_data <= wd;
    predict_timer_response(func, bank, off, wd, rsp);
    expected_rsp_q.push_back(rsp);
    requests_sent++;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Holds the request side idle until every outstanding response has come back.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void note_failure(input string what, input timer_rsp_t want,
                                       input timer_rsp_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t %s: expected data %h irq %b bad %b, got data %h irq %b bad %b",
               $realtime, what, want.read_data, want.irq, want.bad_access,
               got.read_data, got.irq, got.bad_access);
    end
  endfunction

  // Response stall: a fresh random wait before each response, none in steady traffic.
  initial begin
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = steady_traffic ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
    end
  end

  // Response checker: each accepted response against the oldest expectation.
  always @(posedge clk_i) begin
    timer_rsp_t got;
    timer_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got.read_data  = rsp_ch.read_data;
      got.irq        = {rsp_ch.irq_tclock, rsp_ch.irq_long2, rsp_ch.irq_long1,
                        rsp_ch.irq_elapsed};
      got.bad_access = rsp_ch.bad_access;
      if (expected_rsp_q.size() == 0) begin
        note_failure("response with no request outstanding", '0, got);
      end else begin
        want = expected_rsp_q.pop_front();
        if (got.read_data !== want.read_data || got.irq !== want.irq ||
            got.bad_access !== want.bad_access) begin
          note_failure("response mismatch", want, got);
        end
      end
    end
  end

  // Register read-back at full width, ignored count writes and undecoded offsets.
  task automatic test_register_map();
    send_req(FUNC_WRITE, BANK_RTC1, OFF_L1_REL_L, 16'hFFFF);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_L1_REL_H, 16'hFFFF);
    send_req(FUNC_READ,  BANK_RTC1, OFF_L1_CNT_H, 16'h0000);
    send_req(FUNC_WRITE, BANK_RTC2, OFF_TC_REL_H, 16'hFFFF);
    send_req(FUNC_READ,  BANK_RTC2, OFF_TC_REL_H, 16'h0000);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_L2_CNT_L, 16'h5A5A);
    send_req(FUNC_READ,  BANK_RTC1, OFF_BANK0_HOLE, 16'h0000);
    send_req(FUNC_READ,  BANK_RTC1, OFF_ODD, 16'h0000);
    send_req(FUNC_WRITE, BANK_RTC2, OFF_BANK1_HOLE, 16'hFFFF);
    send_req(FUNC_READ,  BANK_RTC2, OFF_BANK1_FAR, 16'h0000);
  endtask

  // Compare at its top value, staged elapsed load hitting it, then elapsed wrap.
  task automatic test_alarm_and_elapsed_wrap();
    send_req(FUNC_WRITE, BANK_RTC1, OFF_ECMP_L, 16'hFFFF);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_ECMP_M, 16'hFFFF);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_ECMP_H, 16'hFFFF);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_ETIME_L, 16'hFFFF);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_ETIME_M, 16'hFFFF);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_ETIME_H, 16'hFFFF);
    send_req(FUNC_RTC_TICK, BANK_RTC1, OFF_ETIME_L, 16'h0000);
    send_req(FUNC_READ,  BANK_RTC1, OFF_ETIME_H, 16'h0000);
  endtask

  // Short reloads so that the long1 and tclock down counters wrap and raise their status bits.
  task automatic test_periodic_reload();
    send_req(FUNC_WRITE, BANK_RTC1, OFF_L1_REL_H, 16'h0000);
    send_req(FUNC_WRITE, BANK_RTC1, OFF_L1_REL_L, 16'h0001);
    send_req(FUNC_WRITE, BANK_RTC2, OFF_TC_REL_H, 16'h0000);
    send_req(FUNC_WRITE, BANK_RTC2, OFF_TC_REL_L, 16'h0001);
    send_req(FUNC_RTC_TICK, BANK_RTC1, OFF_ETIME_L, 16'h0000);
    send_req(FUNC_TCLK_TICK, BANK_RTC1, OFF_ETIME_L, 16'h0000);
    send_req(FUNC_WRITE, BANK_RTC2, OFF_INT_STAT, 16'h0003);
  endtask

  // The partial reset keeps everything but the tclock counter and its status bit; the full one clears all.
  task automatic test_resets();
    send_req(FUNC_OTHER_RST, BANK_RTC1, OFF_ETIME_L, 16'h0000);
    send_req(FUNC_READ,  BANK_RTC2, OFF_TC_REL_L, 16'h0000);
    send_req(FUNC_RTC_RST, BANK_RTC1, OFF_ETIME_L, 16'h0000);
    send_req(FUNC_READ,  BANK_RTC2, OFF_INT_STAT, 16'h0000);
  endtask

  // Mostly well-formed register sequences and tick bursts, with some raw noise.
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned target;
    int unsigned next_chunk;
    int unsigned kind;
    int unsigned n;
    int unsigned which;
    logic [47:0] value;
    logic        bank;
    logic [4:0]  off;
    logic [4:0]  off_hi;
    start      = requests_sent;
    target     = requests_sent + 1300;
    next_chunk = requests_sent;
    while (requests_sent < target) begin
      // Every hundred requests pick the traffic style; now and then drain fully.
      if (requests_sent >= next_chunk) begin
        if ((next_chunk - start) % 400 == 0 && next_chunk != start) begin
          wait_for_drain();
        end
        steady_traffic = ($urandom_range(0, 3) == 0);
        next_chunk     = next_chunk + 100;
      end
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        n = $urandom_range(1, 6);
        repeat (n) send_req(FUNC_RTC_TICK, 1'($urandom_range(0, 1)),
                            5'($urandom_range(0, 31)), 16'($urandom_range(0, 16'hFFFF)));
      end else if (kind < 35) begin
        n = $urandom_range(1, 6);
        repeat (n) send_req(FUNC_TCLK_TICK, 1'($urandom_range(0, 1)),
                            5'($urandom_range(0, 31)), 16'($urandom_range(0, 16'hFFFF)));
      end else if (kind < 50) begin
        // Program a reload, usually short so that it wraps soon.
        which       = $urandom_range(0, 2);
        value[31:0] = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 10);
        case (which)
          0: begin
            bank = BANK_RTC1;
            off  = OFF_L1_REL_L;
            off_hi = OFF_L1_REL_H;
          end
          1: begin
            bank = BANK_RTC1;
            off  = OFF_L2_REL_L;
            off_hi = OFF_L2_REL_H;
          end
          default: begin
            bank = BANK_RTC2;
            off  = OFF_TC_REL_L;
            off_hi = OFF_TC_REL_H;
          end
        endcase
        if ($urandom_range(0, 3) != 0) begin
          send_req(FUNC_WRITE, bank, off_hi, {value[31:25], value[24:16]});
        end
        send_req(FUNC_WRITE, bank, off, value[15:0]);
      end else if (kind < 65) begin
        bank = 1'($urandom_range(0, 1));
        if (bank == BANK_RTC1) begin
          off = 5'($urandom_range(0, 15) * 2);
        end else begin
          case ($urandom_range(0, 4))
            0:       off = OFF_TC_REL_L;
            1:       off = OFF_TC_REL_H;
            2:       off = OFF_TC_CNT_L;
            3:       off = OFF_TC_CNT_H;
            default: off = OFF_INT_STAT;
          endcase
        end
        send_req(FUNC_READ, bank, off, 16'($urandom_range(0, 16'hFFFF)));
      end else if (kind < 73) begin
        send_req(FUNC_WRITE, BANK_RTC2, OFF_INT_STAT, 16'($urandom_range(0, 16'hFFFF)));
      end else if (kind < 83) begin
        // Arm the alarm a few ticks ahead of the elapsed counter.
        value = elapsed_q + 48'($urandom_range(0, 12));
        send_req(FUNC_WRITE, BANK_RTC1, OFF_ECMP_L, value[15:0]);
        send_req(FUNC_WRITE, BANK_RTC1, OFF_ECMP_M, value[31:16]);
        send_req(FUNC_WRITE, BANK_RTC1, OFF_ECMP_H, value[47:32]);
      end else if (kind < 90) begin
        // Load elapsed near its top, near compare or anywhere; sometimes left staged.
        case ($urandom_range(0, 2))
          0: value = {36'hFFFFFFFFF, 12'($urandom_range(0, 12'hFFF))};
          1: value = alarm_cmp_q - 48'($urandom_range(0, 8));
          default: begin
            value[47:32] = 16'($urandom_range(0, 16'hFFFF));
            value[31:0]  = $urandom;
          end
        endcase
        send_req(FUNC_WRITE, BANK_RTC1, OFF_ETIME_L, value[15:0]);
        send_req(FUNC_WRITE, BANK_RTC1, OFF_ETIME_M, value[31:16]);
        if ($urandom_range(0, 4) != 0) begin
          send_req(FUNC_WRITE, BANK_RTC1, OFF_ETIME_H, value[47:32]);
        end
      end else if (kind < 93) begin
        if ($urandom_range(0, 2) == 0) begin
          send_req(FUNC_RTC_RST, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                   16'($urandom_range(0, 16'hFFFF)));
        end else begin
          send_req(FUNC_OTHER_RST, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                   16'($urandom_range(0, 16'hFFFF)));
        end
      end else begin
        send_req(func_e'($urandom_range(0, 5)), 1'($urandom_range(0, 1)),
                 5'($urandom_range(0, 31)), 16'($urandom_range(0, 16'hFFFF)));
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni            <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_READ;
    req_ch.bank       <= BANK_RTC1;
    req_ch.offset     <= OFF_ETIME_L;
    req_ch.write_data <= '0;
    steady_traffic = 1'b0;
    requests_sent  = 0;
    failures       = 0;
    clear_timer_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_register_map();
    test_alarm_and_elapsed_wrap();
    test_periodic_reload();
    test_resets();
    wait_for_drain();
    test_random_traffic();
    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
